/* rtl/q2e_pkg.sv */
// Package for the quaternion to Euler angle converter.
// Holds the payload structs, datapath widths, pipeline latencies and the CORDIC arctangent table.
// No dependencies.
package q2e_pkg;

	localparam int QW          = 16;           // quaternion component width
	localparam int PW          = 32;           // product width
	localparam int OPW         = 34;           // atan2 operand width
	localparam int DENW        = 33;           // quaternion norm width
	localparam int ANGW        = 34;           // binary angle width, 2^32 is one turn
	localparam int CW          = 36;           // CORDIC x/y datapath width
	localparam int RW          = 62;           // square root remainder width
	localparam int SQRT_STEPS  = 31;           // one result bit per stage
	localparam int PREP_LAT    = 4;            // asin argument preparation stages
	localparam int ISQRT_LAT   = PREP_LAT + SQRT_STEPS;
	localparam int ATAN_FIXED_LAT = 8;         // atan2 stages besides the rotations
	localparam int SCALE_LAT   = 2;
	localparam int PROD_LAT    = 2;

	localparam logic signed [ANGW-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [ANGW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	typedef logic signed [OPW-1:0]  opnd_t;
	typedef logic signed [ANGW-1:0] angle_t;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic               pitch_clamped;
	} euler_t;

	// Side information of the pitch path
	typedef struct packed {
		logic neg;        // asin argument negative
		logic den_zero;   // zero quaternion
		logic at_limit;   // |argument| >= 1
		logic over;       // |argument| > 1
	} pitch_flags_t;

	// atan(2^-i) as a binary angle
	function automatic logic [29:0] atan_bin(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:    r = 30'd536870912;
			5'd1:    r = 30'd316933406;
			5'd2:    r = 30'd167458907;
			5'd3:    r = 30'd85004756;
			5'd4:    r = 30'd42667331;
			5'd5:    r = 30'd21354465;
			5'd6:    r = 30'd10679838;
			5'd7:    r = 30'd5340245;
			5'd8:    r = 30'd2670163;
			5'd9:    r = 30'd1335087;
			5'd10:   r = 30'd667544;
			5'd11:   r = 30'd333772;
			5'd12:   r = 30'd166886;
			5'd13:   r = 30'd83443;
			5'd14:   r = 30'd41722;
			5'd15:   r = 30'd20861;
			5'd16:   r = 30'd10430;
			5'd17:   r = 30'd5215;
			5'd18:   r = 30'd2608;
			5'd19:   r = 30'd1304;
			5'd20:   r = 30'd652;
			5'd21:   r = 30'd326;
			5'd22:   r = 30'd163;
			5'd23:   r = 30'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/quaternion_to_euler.sv */
// Top level of the quaternion to yaw/pitch/roll (Z-Y-X) converter.
// Depends on q2e_pkg, q2e_prod, q2e_asin, q2e_delay, q2e_atan2 and q2e_scale.
//
// Channel   Signals                        Payload
// quat      quat_valid / quat_ready        q2e_pkg::quat_t  (w, x, y, z, signed Q14)
// euler     euler_valid / euler_ready      q2e_pkg::euler_t (yaw, pitch, roll, clamp flag)
// cfg       cfg_valid / cfg_ready          cfg_data: 1 = degrees Q8.7, 0 = radians Q2.13
//
// One quaternion per cycle is taken unless stalled; the pipeline depth is set by the
// 31-stage square root of the pitch path followed by the atan2 rotation stages.
// All stages move on one enable that drops only when the output register holds an
// untaken transaction; a stall freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and selects degrees.
module quaternion_to_euler #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             quat_valid,
	output logic             quat_ready,
	input  q2e_pkg::quat_t   quat,
	output logic             euler_valid,
	input  logic             euler_ready,
	output q2e_pkg::euler_t  euler,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	localparam int OPW      = q2e_pkg::OPW;
	localparam int ATAN_LAT = q2e_pkg::ATAN_FIXED_LAT + CORDIC_STEPS;
	localparam int FLW      = $bits(q2e_pkg::pitch_flags_t);

	logic                      en;
	logic                      deg_q;
	logic                      prod_v, asin_v, atan_v;
	q2e_pkg::opnd_t            yaw_y, yaw_x, roll_y, roll_x, num;
	logic [q2e_pkg::DENW-1:0]  den;
	q2e_pkg::opnd_t            asin_a, asin_c;
	q2e_pkg::pitch_flags_t     asin_fl, atan_fl;
	logic [4*OPW-1:0]          yr_in, yr_out;
	q2e_pkg::opnd_t            yaw_y_d, yaw_x_d, roll_y_d, roll_x_d;
	q2e_pkg::angle_t           yaw_b, pitch_raw, roll_b;
	q2e_pkg::angle_t           pitch_lim, pitch_b;
	logic                      clamp_in, clamp_out;
	logic signed [15:0]        yaw_o, pitch_o, roll_o;

	// Advance the whole pipeline unless the output transaction is held
	assign en         = !euler_valid || euler_ready;
	assign quat_ready = en;
	assign cfg_ready  = 1'b1;

	// Output unit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			deg_q <= cfg_data;
		end
	end

	q2e_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (quat_valid),
		.quat      (quat),
		.out_valid (prod_v),
		.yaw_y     (yaw_y),
		.yaw_x     (yaw_x),
		.roll_y    (roll_y),
		.roll_x    (roll_x),
		.num       (num),
		.den       (den)
	);

	q2e_asin u_asin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prod_v),
		.num       (num),
		.den       (den),
		.out_valid (asin_v),
		.out_a     (asin_a),
		.out_c     (asin_c),
		.out_flags (asin_fl)
	);

	// Hold yaw and roll operands until the pitch operands are ready
	assign yr_in = {yaw_y, yaw_x, roll_y, roll_x};

	q2e_delay #(
		.WIDTH (4 * OPW),
		.DEPTH (q2e_pkg::ISQRT_LAT)
	) u_yr_dly (
		.clk  (clk),
		.en   (en),
		.din  (yr_in),
		.dout (yr_out)
	);

	assign {yaw_y_d, yaw_x_d, roll_y_d, roll_x_d} = yr_out;

	q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (asin_v),
		.in_y      (yaw_y_d),
		.in_x      (yaw_x_d),
		.out_valid (),
		.out_angle (yaw_b)
	);

	q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (asin_v),
		.in_y      (asin_a),
		.in_x      (asin_c),
		.out_valid (atan_v),
		.out_angle (pitch_raw)
	);

	q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (asin_v),
		.in_y      (roll_y_d),
		.in_x      (roll_x_d),
		.out_valid (),
		.out_angle (roll_b)
	);

	q2e_delay #(
		.WIDTH (FLW),
		.DEPTH (ATAN_LAT)
	) u_fl_dly (
		.clk  (clk),
		.en   (en),
		.din  (asin_fl),
		.dout (atan_fl)
	);

	// Pitch: zero for a zero quaternion, a quarter turn at or past the limit, then sign
	always_comb begin
		if (atan_fl.den_zero) begin
			pitch_lim = '0;
		end else if (atan_fl.at_limit) begin
			pitch_lim = q2e_pkg::QUARTER_TURN;
		end else begin
			pitch_lim = pitch_raw;
		end
		pitch_b  = atan_fl.neg ? -pitch_lim : pitch_lim;
		clamp_in = atan_fl.den_zero | atan_fl.over;
	end

	q2e_delay #(
		.WIDTH (1),
		.DEPTH (q2e_pkg::SCALE_LAT)
	) u_clamp_dly (
		.clk  (clk),
		.en   (en),
		.din  (clamp_in),
		.dout (clamp_out)
	);

	q2e_scale u_yaw_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.deg       (deg_q),
		.in_valid  (atan_v),
		.in_angle  (yaw_b),
		.out_valid (),
		.out_angle (yaw_o)
	);

	q2e_scale u_pitch_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.deg       (deg_q),
		.in_valid  (atan_v),
		.in_angle  (pitch_b),
		.out_valid (euler_valid),
		.out_angle (pitch_o)
	);

	q2e_scale u_roll_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.deg       (deg_q),
		.in_valid  (atan_v),
		.in_angle  (roll_b),
		.out_valid (),
		.out_angle (roll_o)
	);

	// Assemble the result transaction
	always_comb begin
		euler.yaw_angle     = yaw_o;
		euler.pitch_angle   = pitch_o;
		euler.roll_angle    = roll_o;
		euler.pitch_clamped = clamp_out;
	end

endmodule

/* rtl/q2e_delay.sv */
// Shift-register delay line that keeps side data aligned with the pipeline.
// Depends on nothing; advances with the shared pipeline enable.
module q2e_delay #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [0:DEPTH-1];

	// Shift the line by one stage on every advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

/* rtl/q2e_prod.sv */
// Quaternion product stage: ten 16x16 products, then the atan2 and asin operand sums.
// Depends on q2e_pkg.
module q2e_prod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  q2e_pkg::quat_t            quat,
	output logic                      out_valid,
	output q2e_pkg::opnd_t            yaw_y,
	output q2e_pkg::opnd_t            yaw_x,
	output q2e_pkg::opnd_t            roll_y,
	output q2e_pkg::opnd_t            roll_x,
	output q2e_pkg::opnd_t            num,
	output logic [q2e_pkg::DENW-1:0]  den
);

	localparam int PW  = q2e_pkg::PW;
	localparam int OPW = q2e_pkg::OPW;
	localparam int DW  = q2e_pkg::DENW;

	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] xy_s1, zw_s1, yz_s1, xw_s1, yw_s1, xz_s1;
	logic                 v_s1, v_s2;
	q2e_pkg::opnd_t       yaw_y_s2, yaw_x_s2, roll_y_s2, roll_x_s2, num_s2;
	logic [DW-1:0]        den_s2;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat.quat_w * quat.quat_w;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			zw_s1 <= quat.quat_z * quat.quat_w;
			yz_s1 <= quat.quat_y * quat.quat_z;
			xw_s1 <= quat.quat_x * quat.quat_w;
			yw_s1 <= quat.quat_y * quat.quat_w;
			xz_s1 <= quat.quat_x * quat.quat_z;
		end
	end

	// Stage 2: operand sums
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_y_s2  <= (OPW'(xy_s1) + OPW'(zw_s1)) <<< 1;
			yaw_x_s2  <= OPW'(xx_s1) - OPW'(yy_s1) - OPW'(zz_s1) + OPW'(ww_s1);
			roll_y_s2 <= (OPW'(yz_s1) + OPW'(xw_s1)) <<< 1;
			roll_x_s2 <= OPW'(zz_s1) + OPW'(ww_s1) - OPW'(xx_s1) - OPW'(yy_s1);
			num_s2    <= (OPW'(yw_s1) - OPW'(xz_s1)) <<< 1;
			den_s2    <= DW'($unsigned(ww_s1)) + DW'($unsigned(xx_s1))
				+ DW'($unsigned(yy_s1)) + DW'($unsigned(zz_s1));
		end
	end

	assign out_valid = v_s2;
	assign yaw_y     = yaw_y_s2;
	assign yaw_x     = yaw_x_s2;
	assign roll_y    = roll_y_s2;
	assign roll_x    = roll_x_s2;
	assign num       = num_s2;
	assign den       = den_s2;

endmodule

/* rtl/q2e_asin.sv */
// asin argument preparation: magnitude, limit flags, norm scaling and a pipelined
// integer square root of den^2 - a^2, one result bit per stage. Depends on q2e_pkg.
module q2e_asin (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  q2e_pkg::opnd_t           num,
	input  logic [q2e_pkg::DENW-1:0] den,
	output logic                     out_valid,
	output q2e_pkg::opnd_t           out_a,
	output q2e_pkg::opnd_t           out_c,
	output q2e_pkg::pitch_flags_t    out_flags
);

	localparam int DW  = q2e_pkg::DENW;
	localparam int RW  = q2e_pkg::RW;
	localparam int NS  = q2e_pkg::SQRT_STEPS;
	localparam int OPW = q2e_pkg::OPW;
	localparam logic [DW-1:0] NORM_LIM = DW'(64'd1 << 30);

	logic [DW-1:0]          a_s1, den_s1;
	logic                   neg_s1, v_s1;
	logic [30:0]            a_s2, d_s2;
	q2e_pkg::pitch_flags_t  fl_s2, fl_s3;
	logic                   v_s2, v_s3;
	logic [30:0]            a_s3, diff_s3;
	logic [31:0]            sum_s3;
	logic [62:0]            prod;
	logic [DW-1:0]          d1, a1, d2, a2;

	logic [RW-1:0]          rem_s [0:NS];
	logic [RW-1:0]          res_s [0:NS];
	logic [30:0]            sa_s  [0:NS];
	q2e_pkg::pitch_flags_t  sf_s  [0:NS];
	logic                   sv_s  [0:NS];

	// Scale the norm down to at most 2^30, with the magnitude alongside
	always_comb begin
		d1 = (den_s1 > NORM_LIM) ? (den_s1 >> 1) : den_s1;
		a1 = (den_s1 > NORM_LIM) ? (a_s1 >> 1) : a_s1;
		d2 = (d1 > NORM_LIM) ? (d1 >> 1) : d1;
		a2 = (d1 > NORM_LIM) ? (a1 >> 1) : a1;
	end

	assign prod = 63'(diff_s3) * 63'(sum_s3);

	// Advance valid bits of the preparation stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			sv_s[0]  <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			sv_s[0]  <= v_s3;
		end
	end

	// Stages 1 to 4: magnitude, flags and scaling, difference and sum, product
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1             <= DW'(num[OPW-1] ? -num : num);
			neg_s1           <= num[OPW-1];
			den_s1           <= den;
			a_s2             <= a2[30:0];
			d_s2             <= d2[30:0];
			fl_s2.neg        <= neg_s1;
			fl_s2.den_zero   <= (den_s1 == '0);
			fl_s2.at_limit   <= (a_s1 >= den_s1);
			fl_s2.over       <= (a_s1 > den_s1);
			a_s3             <= a_s2;
			diff_s3          <= d_s2 - a_s2;
			sum_s3           <= 32'(d_s2) + 32'(a_s2);
			fl_s3            <= fl_s2;
			rem_s[0]         <= prod[RW-1:0];
			res_s[0]         <= '0;
			sa_s[0]          <= a_s3;
			sf_s[0]          <= fl_s3;
		end
	end

	// Square root: one result bit per stage
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [RW-1:0] BIT = RW'(64'd1 << (2 * (NS - 1 - k)));
		logic [RW-1:0] trial;
		logic          fits;
		assign trial = res_s[k] + BIT;
		assign fits  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k+1] <= 1'b0;
			end else if (en) begin
				sv_s[k+1] <= sv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? (rem_s[k] - trial) : rem_s[k];
				res_s[k+1] <= fits ? ((res_s[k] >> 1) + BIT) : (res_s[k] >> 1);
				sa_s[k+1]  <= sa_s[k];
				sf_s[k+1]  <= sf_s[k];
			end
		end
	end

	assign out_valid = sv_s[NS];
	assign out_a     = {3'b000, sa_s[NS]};
	assign out_c     = {3'b000, res_s[NS][30:0]};
	assign out_flags = sf_s[NS];

endmodule

/* rtl/q2e_atan2.sv */
// Pipelined atan2 on a binary angle: half-plane fold, leading-zero normalization in
// five shift stages, then one vectoring CORDIC rotation per stage. Depends on q2e_pkg.
module q2e_atan2 #(
	parameter int STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  q2e_pkg::opnd_t  in_y,
	input  q2e_pkg::opnd_t  in_x,
	output logic            out_valid,
	output q2e_pkg::angle_t out_angle
);

	localparam int CW   = q2e_pkg::CW;
	localparam int ANGW = q2e_pkg::ANGW;
	localparam int NN   = 5;               // normalization shift stages
	localparam int NS   = NN + 1 + STEPS;  // entries of the x/y pipeline

	logic signed [CW-1:0]   x_s1, y_s1;
	q2e_pkg::angle_t        base_s1;
	logic                   zero_s1, v_s1;
	logic [CW-1:0]          ax, ay;

	logic signed [CW-1:0]   x_s  [0:NS-1];
	logic signed [CW-1:0]   y_s  [0:NS-1];
	q2e_pkg::angle_t        b_s  [0:NS-1];
	logic                   zr_s [0:NS-1];
	logic                   v_s  [0:NS-1];
	logic [CW-1:0]          m_s  [0:NN-1];
	q2e_pkg::angle_t        z_s  [0:STEPS-1];

	q2e_pkg::angle_t        ang_q;
	logic                   v_q;

	// Magnitudes for the normalization search
	assign ax = x_s1[CW-1] ? CW'(-x_s1) : CW'(x_s1);
	assign ay = y_s1[CW-1] ? CW'(-y_s1) : CW'(y_s1);

	// Valid bits of the fold and magnitude stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s[0] <= v_s1;
		end
	end

	// Stage 1: fold the left half plane; stage 2: larger magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				x_s1    <= -CW'(in_x);
				y_s1    <= -CW'(in_y);
				base_s1 <= (in_y >= 0) ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN;
			end else begin
				x_s1    <= CW'(in_x);
				y_s1    <= CW'(in_y);
				base_s1 <= '0;
			end
			x_s[0]  <= x_s1;
			y_s[0]  <= y_s1;
			b_s[0]  <= base_s1;
			zr_s[0] <= zero_s1;
			m_s[0]  <= (ax > ay) ? ax : ay;
		end
	end

	// Normalize: shift up until the larger magnitude reaches 2^31
	for (genvar j = 0; j < NN; j++) begin : g_norm
		localparam int SH = 16 >> j;
		localparam logic [CW-1:0] LIM = CW'(64'd1 << (32 - SH));
		logic is_low;
		assign is_low = m_s[j] < LIM;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[j+1]  <= is_low ? (x_s[j] <<< SH) : x_s[j];
				y_s[j+1]  <= is_low ? (y_s[j] <<< SH) : y_s[j];
				b_s[j+1]  <= b_s[j];
				zr_s[j+1] <= zr_s[j];
			end
		end

		if (j < NN - 1) begin : g_mag
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[j+1] <= is_low ? (m_s[j] << SH) : m_s[j];
				end
			end
		end
	end

	// Rotate toward the x axis, one step per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam int P = NN + i;
		localparam q2e_pkg::angle_t ANG = ANGW'(q2e_pkg::atan_bin(5'(i)));
		q2e_pkg::angle_t z_in;
		logic            up;

		if (i == 0) begin : g_first
			assign z_in = '0;
		end else begin : g_next
			assign z_in = z_s[i-1];
		end

		assign up = y_s[P] > 0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[P+1] <= 1'b0;
			end else if (en) begin
				v_s[P+1] <= v_s[P];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[P+1]  <= up ? (x_s[P] + (y_s[P] >>> i)) : (x_s[P] - (y_s[P] >>> i));
				y_s[P+1]  <= up ? (y_s[P] - (x_s[P] >>> i)) : (y_s[P] + (x_s[P] >>> i));
				z_s[i]    <= up ? (z_in + ANG) : (z_in - ANG);
				b_s[P+1]  <= b_s[P];
				zr_s[P+1] <= zr_s[P];
			end
		end
	end

	// Add the fold offset; a zero vector gives angle zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= zr_s[NS-1] ? '0 : (b_s[NS-1] + z_s[STEPS-1]);
		end
	end

	assign out_valid = v_q;
	assign out_angle = ang_q;

endmodule

/* rtl/q2e_scale.sv */
// Binary angle to output unit: degrees Q8.7 or radians Q2.13, rounded half up.
// Radians use two registered partial products. Depends on q2e_pkg.
module q2e_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               deg,
	input  logic               in_valid,
	input  q2e_pkg::angle_t    in_angle,
	output logic               out_valid,
	output logic signed [15:0] out_angle
);

	localparam int ANGW = q2e_pkg::ANGW;
	localparam int LOW  = 17;
	localparam int HIW  = ANGW - LOW;
	localparam logic signed [39:0] DEG_RND = 40'sd2097152;
	localparam logic [67:0]        RAD_RND = 68'd1 << 47;

	logic signed [39:0] dp_s1;
	logic signed [49:0] hp_s1;
	logic [48:0]        lp_s1;
	logic               v_s1, v_s2;
	logic [67:0]        rad_sum;
	logic signed [15:0] ang_s2;
	logic signed [HIW-1:0] hi;
	logic [LOW-1:0]     lo;

	assign hi = in_angle[ANGW-1:LOW];
	assign lo = in_angle[LOW-1:0];
	assign rad_sum = (68'(hp_s1) << LOW) + 68'(lp_s1) + RAD_RND;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: degree product and radian partial products; stage 2: combine and select
	always_ff @(posedge clk) begin
		if (en) begin
			dp_s1  <= 40'(in_angle) * 40'sd45 + DEG_RND;
			hp_s1  <= 50'(hi) * $signed({18'd0, q2e_pkg::PI_Q30});
			lp_s1  <= 49'(lo) * 49'(q2e_pkg::PI_Q30);
			ang_s2 <= deg ? dp_s1[37:22] : rad_sum[63:48];
		end
	end

	assign out_valid = v_s2;
	assign out_angle = ang_s2;

endmodule
